// File: rtl/core/prq_pkg.sv
// -----------------------------------------------------------------------------
// prq_pkg - shared types and constants for the priority ready queue
// Entry, chain link and command types used by the queue cells and the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prq_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TASK_W    = 3;
    localparam int PRIO_W    = 8;
    localparam int CNT_W     = 4;

    localparam logic [PRIO_W-1:0] IDLE_PRIO = 8'hFF;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_ACT    = 2'd1,
        FN_FIN    = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    typedef struct packed {
        logic              valid;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Handed from each cell to the next one down the row
    typedef struct packed {
        logic   hit_seen;   // an entry ahead of this cell is removed
        logic   ins_seen;   // the new item lands ahead of this cell
        logic   lock;       // head slot may not take the new item
        logic   bump;       // new item belonged in the locked head slot, take it here
        t_entry rent;       // previous cell's entry after removal
    } t_link;

    typedef struct packed {
        logic              op_add;
        logic              op_pop;
        logic              commit;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

endpackage

// File: rtl/core/prq_cell.sv
// -----------------------------------------------------------------------------
// prq_cell - one slot of the ready queue
// Holds one entry; takes part in removal and ordered insertion through links
// to its neighbors, and moves its entry on a committed command.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  prq_pkg::t_cmd  i_cmd,
    input  prq_pkg::t_link i_link,
    input  prq_pkg::t_entry i_up_ent,
    output prq_pkg::t_link o_link,
    output prq_pkg::t_entry o_ent,
    output prq_pkg::t_entry o_next
);
    import prq_pkg::*;

    logic                r_valid;
    logic [TASK_W-1:0]   r_task;
    logic [PRIO_W-1:0]   r_prio;
    t_entry              cur;
    t_entry              rent;
    t_entry              newent;
    t_entry              n_ent;
    logic                hit_here;
    logic                hit_thru;
    logic                fits;
    logic                cand;

    assign cur = '{valid: r_valid, task_id: r_task, prio: r_prio};
    assign newent = '{valid: 1'b1, task_id: i_cmd.task_id, prio: i_cmd.prio};

    always_comb begin
        hit_here = i_cmd.op_add && r_valid && (r_task == i_cmd.task_id);
        hit_thru = i_link.hit_seen || hit_here;
        // close the gap left by a removed entry
        rent     = hit_thru ? i_up_ent : cur;
        fits     = !rent.valid || (rent.prio >= i_cmd.prio);
        cand     = i_cmd.op_add && (i_link.bump || (!i_link.lock && fits));
        priority if (i_cmd.op_add) begin
            if (i_link.ins_seen) begin
                n_ent = i_link.rent;
            end else if (cand) begin
                n_ent = newent;
            end else begin
                n_ent = rent;
            end
        end else if (i_cmd.op_pop) begin
            n_ent = rent;
        end else begin
            n_ent = cur;
        end
    end

    assign o_link = '{hit_seen: hit_thru, ins_seen: i_link.ins_seen || cand,
                      lock: 1'b0, bump: i_cmd.op_add && i_link.lock && fits,
                      rent: rent};
    assign o_ent  = cur;
    assign o_next = i_cmd.commit ? n_ent : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_valid <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_task <= n_ent.task_id;
            r_prio <= n_ent.prio;
        end
    end

endmodule

// File: rtl/core/priority_ready_queue.sv
// -----------------------------------------------------------------------------
// priority_ready_queue - ordered ready queue for a run-to-completion scheduler
// Keeps up to eight task ids sorted by urgency in a row of cells and reports
// the head, the running state and a preempt flag after every command.
// -----------------------------------------------------------------------------
// One command is accepted per clock cycle while the output is not stalled, and
// completes in the cycle it is accepted: removal and ordered insertion ripple
// through the eight queue cells in that cycle, so the row of cells sets the
// cycle time, not the rate. Its result appears in the output register on the
// next cycle. While that result is held by i_out_stall the input stalls; a new
// command is accepted in the same cycle that the waiting result is taken.
// No clearing pass after reset.
`timescale 1ns / 1ps

module priority_ready_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_func,
    input  logic [prq_pkg::TASK_W-1:0] i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0] i_task_priority,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_head_valid,
    output logic [prq_pkg::TASK_W-1:0] o_head_task,
    output logic [prq_pkg::PRIO_W-1:0] o_head_priority,
    output logic                      o_head_running,
    output logic [prq_pkg::PRIO_W-1:0] o_current_priority,
    output logic                      o_preempt_pending,
    output logic                      o_ignored,
    output logic [prq_pkg::CNT_W-1:0]  o_queue_count
);
    import prq_pkg::*;

    t_link             links [MAX_TASKS+1];
    t_entry            ents  [MAX_TASKS+1];
    t_entry            nexts [MAX_TASKS];
    t_cmd              cmd;
    t_func             func;
    t_entry            head_next;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_running;
    logic              n_running;
    logic [PRIO_W-1:0] r_level;
    logic [PRIO_W-1:0] n_level;
    logic              r_out_valid;
    logic              accept;
    logic              ign;
    logic              match_any;
    logic              head_is_id;

    logic              r_hv;
    logic [TASK_W-1:0] r_ht;
    logic [PRIO_W-1:0] r_hp;
    logic              r_hr;
    logic [PRIO_W-1:0] r_cur;
    logic              r_pre;
    logic              r_ign;
    logic [CNT_W-1:0]  r_cnt;

    assign func       = t_func'(i_func);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign cmd.op_add  = (func == FN_ADD);
    assign cmd.op_pop  = (func == FN_FIN);
    assign cmd.task_id = i_task_id;
    assign cmd.prio    = i_task_priority;
    assign cmd.commit  = accept && !ign && (cmd.op_add || cmd.op_pop);

    // cell zero starts the chain: pop removes it, a running head keeps its slot
    assign links[0] = '{hit_seen: cmd.op_pop, ins_seen: 1'b0,
                        lock: cmd.op_add && r_running, bump: 1'b0, rent: '0};
    assign ents[MAX_TASKS] = '0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        prq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_link   (links[g]),
            .i_up_ent (ents[g+1]),
            .o_link   (links[g+1]),
            .o_ent    (ents[g]),
            .o_next   (nexts[g])
        );
    end

    assign match_any  = cmd.op_add && links[MAX_TASKS].hit_seen;
    assign head_is_id = ents[0].valid && (ents[0].task_id == i_task_id);
    assign head_next  = nexts[0];

    always_comb begin
        ign       = 1'b1;
        n_count   = r_count;
        n_running = r_running;
        n_level   = r_level;
        unique case (func)
            FN_ADD: begin
                ign = (CNT_W'(i_task_id) >= CNT_W'(MAX_TASKS)) || head_is_id
                      || (!match_any && (r_count == CNT_W'(MAX_TASKS)));
                if (!ign) begin
                    n_count = r_count + CNT_W'(1) - CNT_W'(match_any);
                end
            end
            FN_ACT: begin
                ign = (r_count == '0) || r_running;
                if (!ign) begin
                    n_running = 1'b1;
                    n_level   = ents[0].prio;
                end
            end
            FN_FIN: begin
                ign = (r_count == '0);
                if (!ign) begin
                    n_count   = r_count - CNT_W'(1);
                    n_running = 1'b0;
                    if (r_count == CNT_W'(1)) begin
                        n_level = IDLE_PRIO;
                    end
                end
            end
            FN_UNUSED: begin
                ign = 1'b1;
            end
            default: begin
                ign = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_running   <= 1'b0;
            r_level     <= IDLE_PRIO;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_running <= n_running;
                r_level   <= n_level;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register: state after the command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hv  <= head_next.valid;
            r_ht  <= head_next.valid ? head_next.task_id : '0;
            r_hp  <= head_next.valid ? head_next.prio : '0;
            r_hr  <= n_running;
            r_cur <= n_level;
            r_pre <= head_next.valid && (head_next.prio < n_level);
            r_ign <= ign;
            r_cnt <= n_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_head_valid       = r_hv;
    assign o_head_task        = r_ht;
    assign o_head_priority    = r_hp;
    assign o_head_running     = r_hr;
    assign o_current_priority = r_cur;
    assign o_preempt_pending  = r_pre;
    assign o_ignored          = r_ign;
    assign o_queue_count      = r_cnt;

endmodule

// File: rtl/core/prq_checker.sv
// -----------------------------------------------------------------------------
// prq_checker - port-level checks for the priority ready queue
// Watches the result channel for consistent queue reports and a held result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_head_valid,
    input logic                       o_head_running,
    input logic                       o_preempt_pending,
    input logic [prq_pkg::PRIO_W-1:0] o_current_priority,
    input logic [prq_pkg::CNT_W-1:0]  o_queue_count
);
    import prq_pkg::*;

    a_count_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_head_valid == (o_queue_count != '0)))
        else $error("head valid disagrees with queue count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_count <= CNT_W'(MAX_TASKS)))
        else $error("queue count beyond capacity");

    a_running_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_head_running |-> o_head_valid && !o_preempt_pending)
        else $error("running or preempt report without a head");

    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_head_valid |-> (o_current_priority == IDLE_PRIO))
        else $error("empty queue with non-idle current priority");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled item dropped");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_head_valid       (o_head_valid),
    .o_head_running     (o_head_running),
    .o_preempt_pending  (o_preempt_pending),
    .o_current_priority (o_current_priority),
    .o_queue_count      (o_queue_count)
);
